>>> design/mrwt_pkg.sv
// Shared types for the Miller-Rabin witness test block.
package mrwt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_POW,
        ST_POW_SQ,
        ST_TEST,
        ST_SQ_LOOP,
        ST_SQ_CHK,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_FINISH
    } t_state;

    typedef enum logic {
        DST_RES,
        DST_SQ
    } t_dest;

    localparam int unsigned OUT_BYTES = 1;

endpackage

>>> design/miller_rabin_witness_test.sv
// Miller-Rabin witness test: one round per request, one shared modular adder.
//
// Each request carries an odd candidate n and a witness a; only the low WIDTH
// bits of each are used. The block splits n-1 = d * 2^s, forms a^d mod n by
// right-to-left square-and-multiply, then squares up to s-1 more times, and
// returns probably_prime (the witness does not prove n composite) together with
// bad_input (n even, n < 5, or a outside [2, n-2]; probably_prime is then 0).
// All arithmetic goes through one modular adder, (x + y) mod n, used once per
// clock. A modular multiply doubles the accumulator for each of the WIDTH
// multiplier bits and adds the multiplicand for each set bit. A request is
// checked and n-1 is split into d and s, then a^d takes (bits of d - 1)
// squarings and (set bits of d) products, and at most s - 1 further squarings
// follow. The block takes one request at a time: s_axis_tready is high only
// while it is idle. The result sits in an output register, so the next request
// is taken while a finished result still waits for m_axis_tready. Bad inputs
// go from the check straight to the finish state. There is no reset sweep;
// reset clears only the sequencer and the output valid flag.
module miller_rabin_witness_test
    import mrwt_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] candidate, [127:64] witness
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata    // [0] probably_prime, [1] bad_input, rest zero
);

    localparam int CW = $clog2(WIDTH);

    // Sequencer
    t_state r_state, n_state;
    t_state r_ret, n_ret;              // where a multiply returns to
    t_dest  r_dest, n_dest;            // which register takes the product

    // Operands and working values
    logic [WIDTH-1:0] r_n,   n_n;      // modulus (candidate)
    logic [WIDTH-1:0] r_a,   n_a;      // witness
    logic [WIDTH-1:0] r_d,   n_d;      // exponent, shifted right as it is used
    logic [CW-1:0]    r_s,   n_s;      // power of two, then squarings left
    logic [WIDTH-1:0] r_res, n_res;    // running result y
    logic [WIDTH-1:0] r_sq,  n_sq;     // running square of the base

    // Serial multiplier
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_mx,  n_mx;     // multiplicand
    logic [WIDTH-1:0] r_my,  n_my;     // multiplier, MSB first
    logic [CW-1:0]    r_cnt, n_cnt;

    // Pending and output results
    logic r_pp,      n_pp;
    logic r_bad,     n_bad;
    logic r_out_valid, n_out_valid;
    logic r_out_pp,    n_out_pp;
    logic r_out_bad,   n_out_bad;

    // Shared modular adder: (opa + opb) mod n for opa, opb < n
    logic [WIDTH-1:0] w_opa, w_opb, w_sum;
    logic [WIDTH:0]   w_raw, w_red;

    logic [WIDTH-1:0] w_nm1;
    logic             w_bad_in;
    logic             w_res_one, w_res_nm1;
    logic             w_load_out;
    logic             w_mul_last;

    assign w_opa = r_acc;
    assign w_opb = (r_state == ST_MUL_ADD) ? r_mx : r_acc;
    assign w_raw = {1'b0, w_opa} + {1'b0, w_opb};
    assign w_red = w_raw - {1'b0, r_n};
    assign w_sum = w_red[WIDTH] ? w_raw[WIDTH-1:0] : w_red[WIDTH-1:0];

    assign w_nm1     = r_n - WIDTH'(1);
    assign w_res_one = (r_res == WIDTH'(1));
    assign w_res_nm1 = (r_res == w_nm1);

    // Reject even or tiny candidates and witnesses outside [2, n-2]
    assign w_bad_in = !r_n[0] || (r_n < WIDTH'(5)) || (r_a < WIDTH'(2))
                      || (r_a > (r_n - WIDTH'(2)));

    assign w_load_out = !r_out_valid || m_axis_tready;
    assign w_mul_last = (r_cnt == '0);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_bad, r_out_pp};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = w_bad_in ? ST_FINISH : ST_SPLIT;
            end
            ST_SPLIT: begin
                if (r_d[0]) n_state = ST_POW;
            end
            ST_POW: begin
                n_state = r_d[0] ? ST_MUL_DBL : ST_POW_SQ;
            end
            ST_POW_SQ: begin
                n_state = (r_d[WIDTH-1:1] != '0) ? ST_MUL_DBL : ST_TEST;
            end
            ST_TEST: begin
                n_state = (w_res_one || w_res_nm1) ? ST_FINISH : ST_SQ_LOOP;
            end
            ST_SQ_LOOP: begin
                n_state = (r_s == '0) ? ST_FINISH : ST_MUL_DBL;
            end
            ST_SQ_CHK: begin
                n_state = (w_res_one || w_res_nm1) ? ST_FINISH : ST_SQ_LOOP;
            end
            ST_MUL_DBL: begin
                if (r_my[WIDTH-1])   n_state = ST_MUL_ADD;
                else if (w_mul_last) n_state = r_ret;
            end
            ST_MUL_ADD: begin
                n_state = w_mul_last ? r_ret : ST_MUL_DBL;
            end
            ST_FINISH: begin
                if (w_load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb begin
        logic mul_step;

        n_n    = r_n;
        n_a    = r_a;
        n_d    = r_d;
        n_s    = r_s;
        n_res  = r_res;
        n_sq   = r_sq;
        n_acc  = r_acc;
        n_mx   = r_mx;
        n_my   = r_my;
        n_cnt  = r_cnt;
        n_ret  = r_ret;
        n_dest = r_dest;
        n_pp   = r_pp;
        n_bad  = r_bad;
        n_out_pp  = r_out_pp;
        n_out_bad = r_out_bad;
        // drop the result once the sink takes it
        n_out_valid = r_out_valid && !m_axis_tready;
        mul_step = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_n = s_axis_tdata[WIDTH-1:0];
                    n_a = s_axis_tdata[64 +: WIDTH];
                end
            end
            ST_CHECK: begin
                n_pp  = 1'b0;
                n_bad = w_bad_in;
                n_d   = w_nm1;
                n_s   = '0;
            end
            ST_SPLIT: begin
                if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_s = r_s + CW'(1);
                end else begin
                    n_res = WIDTH'(1);
                    n_sq  = r_a;
                end
            end
            ST_POW: begin
                if (r_d[0]) begin
                    n_acc  = '0;
                    n_mx   = r_res;
                    n_my   = r_sq;
                    n_cnt  = CW'(WIDTH - 1);
                    n_dest = DST_RES;
                    n_ret  = ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                n_d = r_d >> 1;
                if (r_d[WIDTH-1:1] != '0) begin
                    n_acc  = '0;
                    n_mx   = r_sq;
                    n_my   = r_sq;
                    n_cnt  = CW'(WIDTH - 1);
                    n_dest = DST_SQ;
                    n_ret  = ST_POW;
                end
            end
            ST_TEST: begin
                if (w_res_one || w_res_nm1) n_pp = 1'b1;
                else                         n_s  = r_s - CW'(1);
            end
            ST_SQ_LOOP: begin
                if (r_s != '0) begin
                    n_s    = r_s - CW'(1);
                    n_acc  = '0;
                    n_mx   = r_res;
                    n_my   = r_res;
                    n_cnt  = CW'(WIDTH - 1);
                    n_dest = DST_RES;
                    n_ret  = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK: begin
                if (w_res_nm1) n_pp = 1'b1;
            end
            ST_MUL_DBL: begin
                n_acc    = w_sum;
                mul_step = !r_my[WIDTH-1];
            end
            ST_MUL_ADD: begin
                n_acc    = w_sum;
                mul_step = 1'b1;
            end
            ST_FINISH: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_out_pp    = r_pp;
                    n_out_bad   = r_bad;
                end
            end
            default: ;
        endcase

        // advance the multiplier bit, or hand the product over on the last one
        if (mul_step) begin
            if (w_mul_last) begin
                unique case (r_dest)
                    DST_RES: n_res = w_sum;
                    DST_SQ:  n_sq  = w_sum;
                    default: ;
                endcase
            end else begin
                n_cnt = r_cnt - CW'(1);
                n_my  = r_my << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_ret     <= n_ret;
        r_dest    <= n_dest;
        r_n       <= n_n;
        r_a       <= n_a;
        r_d       <= n_d;
        r_s       <= n_s;
        r_res     <= n_res;
        r_sq      <= n_sq;
        r_acc     <= n_acc;
        r_mx      <= n_mx;
        r_my      <= n_my;
        r_cnt     <= n_cnt;
        r_pp      <= n_pp;
        r_bad     <= n_bad;
        r_out_pp  <= n_out_pp;
        r_out_bad <= n_out_bad;
    end

    // The accumulator and multiplicand are reduced below the modulus at each add step
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_ADD) |-> ((r_acc < r_n) && (r_mx < r_n)))
        else $error("multiplier operand not reduced");

    // A result never claims both a rejected input and a prime verdict
    a_out_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("bad_input and probably_prime both set");

    // Exponentiation only runs with a nonzero exponent
    a_pow_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POW) |-> (r_d != '0))
        else $error("exponent ran out inside exponentiation");

    // An accepted request is checked on the next cycle
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_CHECK))
        else $error("accepted request not checked");

endmodule

>>> sim/tb_miller_rabin_witness_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Miller-Rabin witness test block.
module tb_miller_rabin_witness_test;
    import mrwt_pkg::*;

    localparam int W              = 64;       // operand width of the block under test
    localparam int CLK_HALF       = 2;        // 4 ns period
    localparam int RESET_CYCLES   = 6;
    // Slowest request: ~125 serial modular multiplies, plus the longest sender
    // gap and receiver hold-off; take that several times over.
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 400;      // long receiver hold-off
    localparam int DRAIN_CYCLES   = 50;       // quiet time after the last result
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_COUNT   = 70;

    // One result byte, lowest bit first: probably_prime, bad_input, zero padding.
    typedef struct packed {
        logic [8*OUT_BYTES-3:0] pad;
        logic                   bad_input;
        logic                   probably_prime;
    } t_verdict;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [127:0]           s_axis_tdata  = '0;   // [63:0] candidate, [127:64] witness
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [8*OUT_BYTES-1:0] m_axis_tdata;         // [0] probably_prime, [1] bad_input

    t_verdict verdicts_due[$];     // predicted results, oldest first
    int       fault_count  = 0;    // mismatches, unexpected results
    int       quiet_cycles = 0;    // cycles since the last handshake on either side
    int       burst_left   = 0;    // requests left in the current sender burst

    // Receiver hold-off control: the test toggles hold_go, the receiver follows.
    bit       hold_go   = 1'b0;
    bit       hold_seen = 1'b0;
    int       hold_left = 0;
    bit       run_ready = 1'b1;
    int       run_left  = 0;

    miller_rabin_witness_test #(.WIDTH(W)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: modular arithmetic at the block's width, built only from
    // a modular add, so no intermediate value grows past W bits.
    // ------------------------------------------------------------------

    // (x + y) mod m for x, y < m
    function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, y, m);
        logic [W-1:0] room;
        room = m - y;
        return (x >= room) ? x - room : x + y;
    endfunction

    // (x * y) mod m by doubling from the top multiplier bit down
    function automatic logic [W-1:0] mod_mul(input logic [W-1:0] x, y, m);
        logic [W-1:0] acc;
        acc = '0;
        for (int i = W - 1; i >= 0; i--) begin
            acc = mod_add(acc, acc, m);
            if (y[i])
                acc = mod_add(acc, x, m);
        end
        return acc;
    endfunction

    // base^e mod m, scanning the exponent from its low bit
    function automatic logic [W-1:0] mod_pow(input logic [W-1:0] base, e, m);
        logic [W-1:0] acc, sq;
        acc = W'(1);
        sq  = base;
        while (e != 0) begin
            if (e[0])
                acc = mod_mul(acc, sq, m);
            e = e >> 1;
            if (e != 0)
                sq = mod_mul(sq, sq, m);
        end
        return acc;
    endfunction

    // Verdict of one witness round on one candidate.
    function automatic t_verdict witness_verdict(input logic [63:0] cand, wit);
        t_verdict     v;
        logic [W-1:0] n, a, nm1, d, y;
        int           s;
        v   = '0;
        n   = cand[W-1:0];
        a   = wit[W-1:0];
        nm1 = n - 1;
        // Reject even or tiny candidates and witnesses outside [2, n-2].
        if (!n[0] || n < 5 || a < 2 || a > n - 2) begin
            v.bad_input = 1'b1;
            return v;
        end
        // Split n-1 into d * 2^s with d odd.
        d = nm1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        y = mod_pow(a, d, n);
        if (y == 1 || y == nm1) begin
            v.probably_prime = 1'b1;
        end else begin
            for (int j = 1; j < s; j++) begin
                y = mod_mul(y, y, n);
                if (y == 1)
                    break;
                if (y == nm1) begin
                    v.probably_prime = 1'b1;
                    break;
                end
            end
        end
        return v;
    endfunction

    // Trial division, good for the small candidates the random part draws.
    function automatic bit is_small_prime(input logic [63:0] n);
        for (logic [63:0] f = 3; f * f <= n; f += 2)
            if (n % f == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one request, predict its verdict, and queue the
    // prediction once the block accepts it. Bursts of back-to-back requests
    // alternate with gaps, now and then long enough to span a computation.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [63:0] cand, input logic [63:0] wit);
        t_verdict due;
        int       idle;
        due = witness_verdict(cand, wit);
        if (burst_left == 0) begin
            idle = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 3000)
                                               : $urandom_range(0, 12);
            if (idle > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wit, cand};
        // Hold the request until the block takes it.
        do @(posedge i_clk); while (!s_axis_tready);
        verdicts_due.push_back(due);
        burst_left--;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of runs -- long stall-free stretches,
    // short stalls, and fast toggling -- unless a hold-off is requested.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_seen != hold_go) begin
            hold_seen     <= hold_go;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (run_left == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        run_ready = 1'b1;
                        run_left  = $urandom_range(50, 300);
                    end
                    1: begin
                        run_ready = 1'b0;
                        run_left  = $urandom_range(1, 40);
                    end
                    default: begin
                        run_ready = ~run_ready;
                        run_left  = $urandom_range(1, 6);
                    end
                endcase
            end else begin
                run_left--;
            end
            m_axis_tready <= run_ready;
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare every accepted result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (verdicts_due.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: result %h arrived with no request outstanding",
                             $realtime, got);
            end else begin
                want = verdicts_due.pop_front();
                if (got.probably_prime !== want.probably_prime ||
                    got.bad_input !== want.bad_input || got.pad !== want.pad) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $write("%0t: mismatch: probably_prime exp %b got %b, ",
                               $realtime, want.probably_prime, got.probably_prime);
                        $display("bad_input exp %b got %b, pad exp %h got %h",
                                 want.bad_input, got.bad_input, want.pad, got.pad);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("FAIL miller_rabin_witness_test");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Even candidates and candidates below 5, with small witnesses.
    task automatic test_bad_candidates();
        send_request(64'd0, 64'd2);
        send_request(64'd1, 64'd2);
        send_request(64'd2, 64'd0);
        send_request(64'd3, 64'd2);
        send_request(64'd4, 64'd2);
        send_request(64'd6, 64'd3);
        send_request(64'hFFFF_FFFF_FFFF_FFFE, 64'd5);
    endtask

    // Witnesses outside [2, n-2], at both ends and at the top of the field.
    task automatic test_bad_witnesses();
        send_request(64'd5, 64'd0);
        send_request(64'd5, 64'd1);
        send_request(64'd5, 64'd4);                       // n-1
        send_request(64'd97, 64'd97);                     // n
        send_request(64'd97, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    endtask

    // Valid pairs with known outcomes: smallest candidate, strong liars,
    // a Carmichael number, long squaring chains, and the largest operands.
    task automatic test_known_verdicts();
        send_request(64'd5, 64'd2);                       // smallest prime, low witness
        send_request(64'd5, 64'd3);                       // smallest prime, witness n-2
        send_request(64'd561, 64'd2);                     // Carmichael, caught
        send_request(64'd2047, 64'd2);                    // strong pseudoprime to base 2
        send_request(64'd25, 64'd7);                      // strong liar for 25
        send_request(64'd65537, 64'd3);                   // prime, s = 16
        send_request(64'h8000_0000_0000_0001, 64'd3);     // s = 63
        send_request(64'hFFFF_FFFF_FFFF_FFC5, 64'd2);     // largest 64-bit prime
        send_request(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC3);  // witness n-2
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'd2);     // all-ones composite
    endtask

    // Hold the receiver off while requests keep coming, so the output
    // register fills and the block stops taking requests.
    task automatic test_output_stall();
        hold_go    <= ~hold_go;
        burst_left  = 1000;                               // no sender gaps here
        repeat (4) send_request(64'd6, 64'd3);
        send_request(64'd13, 64'd5);
        repeat (4) send_request(64'd9, 64'd9);
        burst_left  = 0;
    endtask

    // Mostly well-formed pairs with random content, small candidates
    // favored; some primes, some long runs of trailing zeros in n-1,
    // a few full-width operands, then broken pairs and raw noise.
    task automatic test_random_requests(input int count);
        logic [63:0] cand, wit;
        int          kind, bits, zeros;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            cand = {$urandom, $urandom};
            wit  = {$urandom, $urandom};
            if (kind < 90) begin
                if ($urandom_range(0, 9) < 7)
                    bits = $urandom_range(3, 24);
                else if ($urandom_range(0, 2) == 0)
                    bits = 64;
                else
                    bits = $urandom_range(25, 63);
                if (bits < 64)
                    cand &= (64'd1 << bits) - 1;
                cand[bits-1] = 1'b1;
                cand[0]      = 1'b1;
                if (kind < 25 && bits <= 20) begin
                    // Advance to the next prime so true verdicts show up.
                    while (!is_small_prime(cand))
                        cand += 2;
                end else if (kind < 45) begin
                    // Clear a run above bit 0 to stretch the squaring chain.
                    zeros = $urandom_range(1, bits - 2);
                    cand  = (cand & ~((64'd1 << (zeros + 1)) - 1)) | 64'd1;
                end
                wit = 64'd2 + wit % (cand - 64'd3);
                if (kind >= 80) begin
                    case ($urandom_range(0, 3))
                        0: wit = cand - $urandom_range(0, 1);
                        1: wit = $urandom_range(0, 1);
                        2: cand[0] = 1'b0;
                        default: wit = cand + wit;
                    endcase
                end
            end
            send_request(cand, wit);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bad_candidates();
        test_bad_witnesses();
        test_known_verdicts();
        test_output_stall();
        test_random_requests(RANDOM_COUNT);

        // Drop valid, let every outstanding result arrive, then watch for strays.
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && verdicts_due.size() == 0)
            $display("PASS miller_rabin_witness_test");
        else
            $display("FAIL miller_rabin_witness_test");
        $finish;
    end

endmodule

>>> sim.f
design/mrwt_pkg.sv
design/miller_rabin_witness_test.sv
sim/tb_miller_rabin_witness_test.sv
